// ----- hdl/mts_pkg.sv -----
// Shared constants, codes and control types for the min-tracking stack.
`default_nettype none
package mts_pkg;

  localparam int DEPTH_DEF      = 1024;
  localparam int DATA_WIDTH_DEF = 32;

  localparam int CFG_W   = 11;
  localparam int COUNT_W = 11;
  localparam int STAT_W  = 2;

  localparam logic [CFG_W-1:0] CAP_RESET = 11'd1024;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_POP  = 1'b1;

  localparam logic [STAT_W-1:0] ST_DONE  = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // take the request on the input ports
    logic capture;  // load the new top entry from the store read
  } mts_cmd_t;

endpackage
`default_nettype wire

// ----- hdl/min_tracking_stack_top.sv -----
// Top level of the min-tracking stack: controller, datapath and ports.
`default_nettype none
// A bounded stack of signed values that reports its minimum at every step
// without a second stack: a push below the running minimum stores the
// encoded entry 2*value - min, and popping such an entry restores the earlier
// minimum as 2*min - entry. Entries are two bits wider than the data, so the
// encoding never overflows. Each request gives exactly one result. A push's
// result is held from the cycle after accept; a pop first passes a read state,
// as the entry under the top comes from the store's registered read port. A
// request is taken in the same cycle the held result is taken, so pushes run at
// one per cycle while out_stall is low; none is taken in a pop's read state.
// The capacity register (reset 1024, limited to DEPTH) is written through the
// cfg port, which is always ready; write it only while no request is in flight.
// The store needs no clearing after reset: unwritten entries read are never used.
module min_tracking_stack_top #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  // request channel
  input  wire logic                         in_valid,
  output      logic                         in_stall,
  input  wire logic                         in_cmd,
  input  wire logic signed [DATA_WIDTH-1:0] in_push_value,
  // result channel
  output      logic                         out_valid,
  input  wire logic                         out_stall,
  output      logic [mts_pkg::STAT_W-1:0]   out_status,
  output      logic signed [DATA_WIDTH-1:0] out_popped_value,
  output      logic signed [DATA_WIDTH-1:0] out_top_value,
  output      logic signed [DATA_WIDTH-1:0] out_min_value,
  output      logic [mts_pkg::COUNT_W-1:0]  out_entry_count,
  output      logic                         out_is_empty,
  output      logic                         out_is_full,
  // capacity register write
  input  wire logic                         cfg_valid,
  output      logic                         cfg_ready,
  input  wire logic [mts_pkg::CFG_W-1:0]    cfg_data
);

  mts_pkg::mts_cmd_t cmd;

  // Capacity writes never wait.
  assign cfg_ready = 1'b1;

  mts_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_cmd   (in_cmd),
    .in_stall (in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .cmd      (cmd)
  );

  // Hold the result fields steady while the result waits.
  mts_dp #(
    .DEPTH     (DEPTH),
    .DATA_WIDTH(DATA_WIDTH)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .in_cmd          (in_cmd),
    .in_push_value   (in_push_value),
    .cfg_we          (cfg_valid && cfg_ready),
    .cfg_data        (cfg_data),
    .out_status      (out_status),
    .out_popped_value(out_popped_value),
    .out_top_value   (out_top_value),
    .out_min_value   (out_min_value),
    .out_entry_count (out_entry_count),
    .out_is_empty    (out_is_empty),
    .out_is_full     (out_is_full)
  );

endmodule
`default_nettype wire

// ----- hdl/mts_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
`default_nettype none
module mts_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 1024
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output      logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mts_ctrl.sv -----
// Controller state machine: handshakes and sequencing of push and pop requests.
`default_nettype none
module mts_ctrl (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  input  wire logic             in_cmd,
  output      logic             in_stall,
  output      logic             out_valid,
  input  wire logic             out_stall,
  output      mts_pkg::mts_cmd_t cmd
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_OUT  = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;
  logic       take;
  logic [1:0] after_take;

  // Accept in idle, or while the held result leaves at this edge.
  assign in_stall   = !((state_r == S_IDLE) || ((state_r == S_OUT) && !out_stall));
  assign take       = in_valid && !in_stall;
  assign out_valid  = (state_r == S_OUT);
  assign after_take = (in_cmd == mts_pkg::CMD_POP) ? S_READ : S_OUT;

  assign cmd.load    = take;
  assign cmd.capture = (state_r == S_READ);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (take) state_nxt = after_take;
      end
      S_READ: begin
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = take ? after_take : S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- hdl/mts_dp.sv -----
// Datapath: entry store, count, running minimum, top entry and result fields.
`default_nettype none
module mts_dp #(
  parameter int DEPTH      = mts_pkg::DEPTH_DEF,
  parameter int DATA_WIDTH = mts_pkg::DATA_WIDTH_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire mts_pkg::mts_cmd_t              cmd,
  input  wire logic                           in_cmd,
  input  wire logic signed [DATA_WIDTH-1:0]   in_push_value,
  input  wire logic                           cfg_we,
  input  wire logic [mts_pkg::CFG_W-1:0]      cfg_data,
  output      logic [mts_pkg::STAT_W-1:0]     out_status,
  output      logic signed [DATA_WIDTH-1:0]   out_popped_value,
  output      logic signed [DATA_WIDTH-1:0]   out_top_value,
  output      logic signed [DATA_WIDTH-1:0]   out_min_value,
  output      logic [mts_pkg::COUNT_W-1:0]    out_entry_count,
  output      logic                           out_is_empty,
  output      logic                           out_is_full
);

  localparam int DW = DATA_WIDTH;
  localparam int EW = DATA_WIDTH + 2;
  localparam int AW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > mts_pkg::CFG_W) ? CW : mts_pkg::CFG_W;
  localparam logic signed [DW-1:0] MAX_POS = {1'b0, {(DW-1){1'b1}}};

  logic [mts_pkg::CFG_W-1:0]  cap_r;
  logic [CW-1:0]              count_r;
  logic signed [DW-1:0]       min_r;
  logic signed [EW-1:0]       top_r;
  logic [mts_pkg::STAT_W-1:0] status_r;
  logic signed [DW-1:0]       popped_r;

  logic [LW-1:0]        count_ext, cap_ext, depth_ext, limit;
  logic                 empty, full;
  logic signed [EW-1:0] x_ext, min_ext, enc, restored, rdata;
  logic                 x_below, top_coded, do_push, do_pop;
  logic [CW-1:0]        rd_cnt;
  logic [AW-1:0]        raddr;

  assign count_ext = LW'(count_r);
  assign cap_ext   = LW'(cap_r);
  assign depth_ext = LW'(DEPTH);
  assign limit     = (cap_ext > depth_ext) ? depth_ext : cap_ext;
  assign empty     = (count_r == '0);
  assign full      = (count_ext >= limit);

  assign x_ext     = EW'(in_push_value);
  assign min_ext   = EW'(min_r);
  assign x_below   = (in_push_value < min_r);
  assign enc       = (x_ext <<< 1) - min_ext;
  assign top_coded = (top_r < min_ext);
  assign restored  = (min_ext <<< 1) - top_r;

  assign do_push = cmd.load && (in_cmd == mts_pkg::CMD_PUSH) && !full;
  assign do_pop  = cmd.load && (in_cmd == mts_pkg::CMD_POP) && !empty;

  // Entry just below the top becomes the new top after a pop.
  assign rd_cnt = count_r - CW'(2);
  assign raddr  = rd_cnt[AW-1:0];

  mts_ram #(
    .WIDTH(EW),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (do_push),
    .waddr(count_r[AW-1:0]),
    .wdata((!empty && x_below) ? enc : x_ext),
    .re   (cmd.load),
    .raddr(raddr),
    .rdata(rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r   <= mts_pkg::CAP_RESET;
      count_r <= '0;
      min_r   <= MAX_POS;
    end else begin
      if (cfg_we) cap_r <= cfg_data;
      if (do_push) begin
        count_r <= count_r + CW'(1);
        if (empty || x_below) min_r <= in_push_value;
      end else if (do_pop) begin
        count_r <= count_r - CW'(1);
        if (top_coded) min_r <= restored[DW-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      top_r <= (!empty && x_below) ? enc : x_ext;
    end else if (cmd.capture) begin
      top_r <= rdata;
    end
    if (cmd.load) begin
      popped_r <= '0;
      if (in_cmd == mts_pkg::CMD_PUSH) begin
        status_r <= full ? mts_pkg::ST_FULL : mts_pkg::ST_DONE;
      end else begin
        status_r <= empty ? mts_pkg::ST_EMPTY : mts_pkg::ST_DONE;
        if (!empty) popped_r <= top_coded ? min_r : top_r[DW-1:0];
      end
    end
  end

  assign out_status       = status_r;
  assign out_popped_value = popped_r;
  assign out_top_value    = empty ? MAX_POS : (top_coded ? min_r : top_r[DW-1:0]);
  assign out_min_value    = empty ? MAX_POS : min_r;
  assign out_entry_count  = count_ext[mts_pkg::COUNT_W-1:0];
  assign out_is_empty     = empty;
  assign out_is_full      = full;

endmodule
`default_nettype wire

// ----- test/min_tracking_stack_top_tb.sv -----
// Self-checking min-tracking stack testbench: directed and random push/pop against a predictor.
`default_nettype none
package mts_check_pkg;
  import mts_pkg::*;

  localparam int DW    = DATA_WIDTH_DEF;
  localparam int EW    = DATA_WIDTH_DEF + 2;
  localparam int DEPTH = DEPTH_DEF;

  localparam logic signed [DW-1:0] MAX_POS = 32'sh7fff_ffff;
  localparam logic signed [DW-1:0] MIN_NEG = 32'sh8000_0000;

  // One result request as it leaves the block.
  typedef struct packed {
    logic [STAT_W-1:0]  status;
    logic signed [DW-1:0] popped;
    logic signed [DW-1:0] top;
    logic signed [DW-1:0] mn;
    logic [COUNT_W-1:0] count;
    logic               empty;
    logic               full;
  } stack_result_t;

  class stack_scoreboard;
    logic signed [EW-1:0] entries [DEPTH];
    logic [COUNT_W-1:0]   fill;
    logic signed [DW-1:0] run_min;
    logic [CFG_W-1:0]     cap;
    stack_result_t        awaited_results[$];
    int                   errors;
    int                   results_seen;

    function new();
      fill         = '0;
      run_min      = MAX_POS;
      cap          = CAP_RESET;
      errors       = 0;
      results_seen = 0;
    endfunction

    function void set_capacity(logic [CFG_W-1:0] value);
      cap = value;
    endfunction

    function int pending();
      return awaited_results.size();
    endfunction

    function logic [COUNT_W-1:0] fill_limit();
      return (cap > DEPTH) ? COUNT_W'(DEPTH) : cap;
    endfunction

    // Apply one accepted request to the shadow stack and queue its result.
    function void take_request(logic cmd, logic signed [DW-1:0] value);
      stack_result_t        r;
      logic signed [EW-1:0] e;
      logic signed [EW-1:0] m_ext;
      logic signed [EW-1:0] v_ext;
      logic signed [EW-1:0] restored;
      r        = '0;
      r.status = ST_DONE;
      m_ext    = run_min;
      v_ext    = value;
      if (cmd == CMD_PUSH) begin
        if (fill >= fill_limit()) begin
          r.status = ST_FULL;
        end else begin
          if (fill != 0 && value < run_min) begin
            // encode: the entry lands below the new minimum
            e       = (v_ext <<< 1) - m_ext;
            run_min = value;
          end else begin
            e = v_ext;
            if (fill == 0) run_min = value;
          end
          entries[fill] = e;
          fill = fill + 1'b1;
        end
      end else if (fill == 0) begin
        r.status = ST_EMPTY;
      end else begin
        e = entries[fill - 1'b1];
        if (e < m_ext) begin
          r.popped = run_min;
          restored = (m_ext <<< 1) - e;
          run_min  = restored[DW-1:0];
        end else begin
          r.popped = e[DW-1:0];
        end
        fill = fill - 1'b1;
      end
      r.count = fill;
      r.empty = (fill == 0);
      r.full  = (fill >= fill_limit());
      if (fill == 0) begin
        r.top = MAX_POS;
        r.mn  = MAX_POS;
      end else begin
        e     = entries[fill - 1'b1];
        m_ext = run_min;
        r.top = (e < m_ext) ? run_min : e[DW-1:0];
        r.mn  = run_min;
      end
      awaited_results.push_back(r);
    endfunction

    task report(string msg);
      $display("ERROR result %0d: %s", results_seen, msg);
      errors++;
    endtask

    task compare_field(string name, logic [DW-1:0] got, logic [DW-1:0] want);
      if (got !== want) report($sformatf("%s got %h want %h", name, got, want));
    endtask

    task check_result(stack_result_t got);
      stack_result_t want;
      if (awaited_results.size() == 0) begin
        report($sformatf("unexpected result, status %0d count %0d", got.status, got.count));
      end else begin
        want = awaited_results.pop_front();
        compare_field("status", DW'(got.status), DW'(want.status));
        compare_field("popped_value", got.popped, want.popped);
        compare_field("top_value", got.top, want.top);
        compare_field("min_value", got.mn, want.mn);
        compare_field("entry_count", DW'(got.count), DW'(want.count));
        compare_field("is_empty", DW'(got.empty), DW'(want.empty));
        compare_field("is_full", DW'(got.full), DW'(want.full));
      end
      results_seen++;
    endtask
  endclass
endpackage

module min_tracking_stack_top_tb;
  import mts_pkg::*;
  import mts_check_pkg::*;

  localparam int          HALF_PERIOD = 4;
  localparam int          SETTLE      = 6;
  localparam int unsigned CYCLE_LIMIT = 400000;

  logic                 clk           = 1'b0;
  logic                 rst_n         = 1'b0;
  logic                 in_valid      = 1'b0;
  logic                 in_stall;
  logic                 in_cmd        = CMD_PUSH;
  logic signed [DW-1:0] in_push_value = '0;
  logic                 out_valid;
  logic                 out_stall     = 1'b0;
  logic [STAT_W-1:0]    out_status;
  logic signed [DW-1:0] out_popped_value;
  logic signed [DW-1:0] out_top_value;
  logic signed [DW-1:0] out_min_value;
  logic [COUNT_W-1:0]   out_entry_count;
  logic                 out_is_empty;
  logic                 out_is_full;
  logic                 cfg_valid     = 1'b0;
  logic                 cfg_ready;
  logic [CFG_W-1:0]     cfg_data      = '0;

  bit                   idle_on       = 1'b1;
  int                   stall_left    = 0;
  int unsigned          cycle_count   = 0;
  stack_result_t        seen_result;
  stack_scoreboard      sb            = new();

  min_tracking_stack_top uut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_cmd           (in_cmd),
    .in_push_value    (in_push_value),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_status       (out_status),
    .out_popped_value (out_popped_value),
    .out_top_value    (out_top_value),
    .out_min_value    (out_min_value),
    .out_entry_count  (out_entry_count),
    .out_is_empty     (out_is_empty),
    .out_is_full      (out_is_full),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_data         (cfg_data)
  );

  always #HALF_PERIOD clk = ~clk;

  // Bound the run: a hung handshake ends here.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("min_tracking_stack_top: mismatch");
      $finish;
    end
  end

  // Result side backpressure: stall in random bursts while idling is on.
  always @(posedge clk) begin
    if (!rst_n || !idle_on) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (stall_left != 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 5) == 0) begin
      out_stall  <= 1'b1;
      stall_left <= $urandom_range(0, 12);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Watch all three channels on the edge. Register writes and requests are
  // noted before results are checked, so a result always finds its
  // expectation queued.
  always @(posedge clk) begin
    if (rst_n) begin
      if (cfg_valid && cfg_ready) sb.set_capacity(cfg_data);
      if (in_valid && !in_stall) sb.take_request(in_cmd, in_push_value);
      if (out_valid && !out_stall) begin
        seen_result.status = out_status;
        seen_result.popped = out_popped_value;
        seen_result.top    = out_top_value;
        seen_result.mn     = out_min_value;
        seen_result.count  = out_entry_count;
        seen_result.empty  = out_is_empty;
        seen_result.full   = out_is_full;
        sb.check_result(seen_result);
      end
    end
  end

  // Hold one request on the input channel until the block takes it,
  // after an optional random gap.
  task automatic send_request(input logic cmd, input logic signed [DW-1:0] value);
    if (idle_on && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_cmd        <= cmd;
    in_push_value <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Drop valid and wait until every queued result has come back, then let
  // the pipeline settle.
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_capacity(input logic [CFG_W-1:0] value);
    drain();
    cfg_valid <= 1'b1;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Favor values at or just below the tracked minimum so encoded entries
  // chain up; mix in the extremes, small values near zero and plain random words.
  function automatic logic signed [DW-1:0] pick_value();
    logic signed [DW-1:0] m;
    m = sb.run_min;
    case ($urandom_range(0, 7))
      0:       return MAX_POS;
      1:       return MIN_NEG;
      2:       return (m == MIN_NEG) ? m : m - 1;
      3:       return m - DW'($urandom_range(0, 1000));
      4:       return DW'($urandom_range(0, 200)) - 100;
      5:       return m;
      default: return $urandom;
    endcase
  endfunction

  task automatic run_mix(input int n, input int push_pct);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(1, 100) <= push_pct) send_request(CMD_PUSH, pick_value());
      else send_request(CMD_POP, $urandom);
      // now and then hold off until the block is empty of work
      if (idle_on && $urandom_range(0, 99) == 0) drain();
    end
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: reset capacity, encode and decode through the extremes.
    send_request(CMD_POP, 32'sd0);          // pop on empty stack
    send_request(CMD_PUSH, 32'sd5);         // push to empty stack
    send_request(CMD_PUSH, 32'sd7);
    send_request(CMD_PUSH, -32'sd3);        // below minimum: encoded
    send_request(CMD_PUSH, MIN_NEG);        // widest negative encoding
    send_request(CMD_PUSH, MAX_POS);
    send_request(CMD_PUSH, MIN_NEG);        // equal to minimum: stored plain
    repeat (6) send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);        // empty again
    send_request(CMD_PUSH, -32'sd1);
    send_request(CMD_PUSH, -32'sd2);
    send_request(CMD_PUSH, -32'sd3);

    // Lower the limit below the count: pushes bounce until pops catch up.
    write_capacity(11'd1);
    send_request(CMD_PUSH, 32'sd9);
    repeat (3) send_request(CMD_POP, $urandom);

    // Zero capacity: full while empty.
    write_capacity(11'd0);
    send_request(CMD_PUSH, MAX_POS);
    send_request(CMD_POP, $urandom);

    write_capacity(11'd2);
    send_request(CMD_PUSH, MAX_POS);
    send_request(CMD_PUSH, MIN_NEG);
    send_request(CMD_PUSH, 32'sd0);
    send_request(CMD_POP, $urandom);
    send_request(CMD_POP, $urandom);

    // Random phases with small limits, idling on and off.
    for (int p = 0; p < 4; p++) begin
      idle_on <= (p != 2);
      write_capacity(CFG_W'($urandom_range(1, 24)));
      run_mix(25, 55);
    end
    write_capacity(CFG_W'($urandom));
    run_mix(20, 50);

    // Last part, no idling: limit above the store depth, fill the store to
    // its end and push past it, then unwind part of the way.
    idle_on <= 1'b0;
    write_capacity(11'h7ff);
    repeat (DEPTH + 2) send_request(CMD_PUSH, pick_value());
    run_mix(30, 30);

    drain();
    if (sb.errors == 0) begin
      $display("min_tracking_stack_top: match");
    end else begin
      $display("min_tracking_stack_top: mismatch");
    end
    $finish;
  end
endmodule
`default_nettype wire

// ----- min_tracking_stack_top.f -----
hdl/mts_pkg.sv
hdl/mts_ram.sv
hdl/mts_ctrl.sv
hdl/mts_dp.sv
hdl/min_tracking_stack_top.sv
test/min_tracking_stack_top_tb.sv
